// ===== rtl/integer_to_ascii_radix_assert.svh =====
// Assertion macros shared by the formatter modules.
`ifndef INTEGER_TO_ASCII_RADIX_ASSERT_SVH
`define INTEGER_TO_ASCII_RADIX_ASSERT_SVH

// A property that must hold whenever the block is out of reset.
`define ITOA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// A property that must hold even during reset.
`define ITOA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/itoa_pkg.sv =====
package itoa_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned MaxChars = 32;
  localparam int unsigned DecDigits = 10;

  typedef enum logic [1:0] {
    BASE_BIN = 2'd0,
    BASE_OCT = 2'd1,
    BASE_DEC = 2'd2,
    BASE_HEX = 2'd3
  } base_t;

  localparam logic [7:0] CharMinus = 8'h2d;

  // One formatted number: digits in place, most significant first.
  typedef struct packed {
    logic [MaxChars-1:0][3:0] digits;
    logic [5:0] first;
    logic neg;
  } fmt_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = 8'h30 + {4'd0, d};
    end else begin
      c = 8'h57 + {4'd0, d};
    end
    return c;
  endfunction

endpackage

// ===== rtl/itoa_conv.sv =====
// Pipelined conversion: prepare, decimal split over ten stages, digit layout.
module itoa_conv (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic [itoa_pkg::ValueW-1:0] in_value,
  input  logic                        in_is_signed,
  input  logic                        in_narrow,
  input  logic [1:0]                  in_opcode,
  input  logic                        adv,
  output logic                        out_valid,
  output itoa_pkg::fmt_t              out_fmt
);
  import itoa_pkg::*;
  `include "integer_to_ascii_radix_assert.svh"

  localparam int unsigned Stages = DecDigits + 2;

  typedef struct packed {
    logic [ValueW-1:0] rem;
    logic [DecDigits-1:0][3:0] dec;
    logic [1:0] base;
    logic neg;
  } work_t;

  logic [Stages-1:0] vld;
  work_t st [Stages-1];
  fmt_t fmt;

  // Stage 0: extension and sign handling.
  logic [ValueW-1:0] v_ext;
  logic neg0;
  always_comb begin
    v_ext = in_value;
    if (in_narrow) begin
      v_ext = {{16{in_is_signed & in_value[15]}}, in_value[15:0]};
    end
    neg0 = in_is_signed && (in_opcode == BASE_DEC) && v_ext[ValueW-1];
    if (neg0) begin
      v_ext = 32'd0 - v_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[Stages-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st[0].rem <= v_ext;
      st[0].dec <= '0;
      st[0].base <= in_opcode;
      st[0].neg <= neg0;
    end
  end

  // Decimal stages: one power of ten per stage by restoring subtraction.
  for (genvar g = 0; g < DecDigits; g++) begin : g_dec
    localparam int unsigned Pos = DecDigits - 1 - g;
    localparam logic [35:0] Pw = 36'(64'd10 ** Pos);
    logic [3:0] q;
    logic [ValueW-1:0] r;
    work_t nxt;
    always_comb begin
      q = '0;
      r = st[g].rem;
      if (st[g].base == BASE_DEC) begin
        for (int k = 3; k >= 0; k--) begin
          if ({4'd0, r} >= (Pw << k)) begin
            r = ValueW'({4'd0, r} - (Pw << k));
            q[k] = 1'b1;
          end
        end
      end
      nxt = st[g];
      nxt.rem = r;
      nxt.dec[Pos] = q;
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        st[g+1] <= nxt;
      end
    end
  end

  // Final stage: digit layout and leading-zero search.
  always_comb begin
    work_t w;
    logic [ValueW-1:0] raw;
    w = st[DecDigits];
    raw = w.rem;
    fmt.digits = '0;
    fmt.neg = w.neg;
    fmt.first = 6'd31;
    case (w.base)
      BASE_BIN: begin
        for (int i = 0; i < 32; i++) fmt.digits[i] = {3'd0, raw[31-i]};
      end
      BASE_OCT: begin
        fmt.digits[21] = {2'd0, raw[31:30]};
        for (int i = 0; i < 10; i++) fmt.digits[22+i] = {1'b0, raw[29-3*i -: 3]};
      end
      BASE_HEX: begin
        for (int i = 0; i < 8; i++) fmt.digits[24+i] = raw[31-4*i -: 4];
      end
      default: begin
        for (int i = 0; i < 10; i++) fmt.digits[22+i] = w.dec[9-i];
      end
    endcase
    for (int i = 31; i >= 0; i--) begin
      if (fmt.digits[i] != 4'd0) fmt.first = 6'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) out_fmt <= fmt;
  end

  assign out_valid = vld[Stages-1];

  `ITOA_ASSERT(a_first_range, out_valid |-> out_fmt.first < 6'd32, "digit start out of range")
  `ITOA_ASSERT(a_dec_small, out_valid && out_fmt.neg |-> out_fmt.first >= 6'd22,
               "negative number too long")
  `ITOA_ASSERT(a_hold, !adv |=> $stable(vld), "pipeline moved while held")

endmodule

// ===== rtl/integer_to_ascii_radix.sv =====
// Path: an accepted item runs through the conversion pipeline and is then
// loaded into the serializer before its first character is offered.
// Throughput: one item per cycle enters the 12-stage conversion pipeline unless
// in_stall is high; the serializer emits one character per cycle unless out_stall
// is high, 1 to 32 per item, so each item's characters set the sustained rate.
// Reset: synchronous, active high; clears all valid bits and the serializer.
module integer_to_ascii_radix (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [itoa_pkg::ValueW-1:0] value,
  input  logic                        is_signed,
  input  logic                        narrow,
  input  logic [1:0]                  opcode,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [7:0]                  char_out,
  output logic                        last
);
  import itoa_pkg::*;
  `include "integer_to_ascii_radix_assert.svh"

  // The pipeline advances whenever the serializer can take its head.
  logic busy;
  logic p_valid;
  fmt_t p_fmt;
  logic adv;
  fmt_t cur;
  logic [5:0] pos;
  logic sign_pend;
  logic at_end;

  // The serializer sits on the final character of its number.
  assign at_end = !sign_pend && (pos == 6'd31);
  // The head is taken when the serializer is idle or hands off its last
  // character in this cycle.
  assign adv = !p_valid || !busy || (!out_stall && at_end);
  assign in_stall = !adv;

  itoa_conv u_conv (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_value(value),
    .in_is_signed(is_signed), .in_narrow(narrow), .in_opcode(opcode),
    .adv(adv), .out_valid(p_valid), .out_fmt(p_fmt)
  );

  // The serializer walks the digit row from the first nonzero digit.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (!busy || !out_stall) begin
      if (!busy || at_end) begin
        busy <= p_valid;
        if (p_valid) begin
          cur <= p_fmt;
          pos <= p_fmt.first;
          sign_pend <= p_fmt.neg;
        end
      end else if (sign_pend) begin
        sign_pend <= 1'b0;
      end else begin
        pos <= pos + 6'd1;
      end
    end
  end

  assign out_valid = busy;
  assign char_out = sign_pend ? CharMinus : digit_char(cur.digits[pos[4:0]]);
  assign last = at_end;

  `ITOA_ASSERT(a_last_no_sign, out_valid && last |-> !sign_pend, "last on minus sign")
  `ITOA_ASSERT(a_out_stall_hold, out_valid && out_stall |=> out_valid && $stable(char_out),
               "stalled character changed")
  `ITOA_ASSERT_ALWAYS(a_pos_range, rst || !busy || pos < 6'd32, "position out of range")

endmodule
